/* hdl/kbc_pkg.sv */
`timescale 1ns / 1ps
package kbc_pkg;

  localparam int unsigned FEAT_W = 16;
  localparam int unsigned TAG_W  = 4;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned DIST_W = 40;
  localparam int unsigned TERM_W = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRAIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_SELECT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [FEAT_W-1:0] feature_value;
    logic [TAG_W-1:0]         class_tag;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0] predicted_class;
    logic             store_empty;
    logic             store_overflowed;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_word_t;

  // control that travels with one feature term through the distance unit
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic l1;
  } dist_ctl_t;

endpackage

/* hdl/kbc_if.sv */
`timescale 1ns / 1ps
interface kbc_in_if;
  import kbc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kbc_out_if;
  import kbc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kbc_cfg_if;
  import kbc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/kbc_dist.sv */
`timescale 1ns / 1ps
module kbc_dist
  import kbc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dist_ctl_t                ctl_i,
  input  logic signed [FEAT_W-1:0] query_i,
  input  logic signed [FEAT_W-1:0] train_i,
  output logic                     done_o,
  output logic [DIST_W-1:0]        dist_o
);

  dist_ctl_t             ctl1_q, ctl2_q;
  logic [FEAT_W-1:0]     mag_q;
  logic [TERM_W-1:0]     term_q;
  logic [DIST_W-1:0]     acc_q;
  logic                  done_q;
  logic signed [FEAT_W:0] diff;
  logic [FEAT_W:0]       diff_abs;
  logic [DIST_W:0]       sum;

  assign diff     = {query_i[FEAT_W-1], query_i} - {train_i[FEAT_W-1], train_i};
  assign diff_abs = diff[FEAT_W] ? 17'(-diff) : 17'(diff);
  assign sum      = (ctl2_q.first ? {(DIST_W+1){1'b0}} : {1'b0, acc_q})
                    + (DIST_W+1)'(term_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.vld && ctl2_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= diff_abs[FEAT_W-1:0];
    term_q <= ctl1_q.l1 ? TERM_W'(mag_q) : mag_q * mag_q;
    // saturate the running sum
    if (ctl2_q.vld) begin
      acc_q <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

/* hdl/knn_brute_classifier_core.sv */
`timescale 1ns / 1ps
// Channel  Dir  Role    Word
// in_i     in   sink    cmd, feature_value, class_tag
// out_o    out  source  predicted_class, store_empty, store_overflowed
// cfg_i    in   sink    register index, write data (always ready)
//
// Feature, command and clear words are accepted whenever the core is idle.
// A query's last feature starts a scan: for each stored point a feature
// memory read, the distance pipeline and a compare, then a sift of the
// heap when the point enters, then a class read and a vote for each
// neighbor.
// Input stays stalled from the last query word until the result is loaded.
// Reset clears counters, flags and the heap; memories stay unwritten.
module knn_brute_classifier_core
  import kbc_pkg::*;
#(
  parameter int unsigned MAX_POINTS     = 256,
  parameter int unsigned MAX_DIMS       = 16,
  parameter int unsigned MAX_NEIGHBOURS = 16,
  parameter int unsigned NUM_CLASSES    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kbc_in_if.sink     in_i,
  kbc_out_if.source  out_o,
  kbc_cfg_if.sink    cfg_i
);

  localparam int unsigned PW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned DCW = $clog2(MAX_DIMS + 1);
  localparam int unsigned KW  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int unsigned KCW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned CLW = $clog2(NUM_CLASSES);
  localparam int unsigned FDEPTH = MAX_POINTS << DW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_WAITD, ST_SDOWN, ST_SUP, ST_VREAD, ST_VACC, ST_DONE
  } state_e;

  state_e state_q;

  // configuration
  logic [CFG_DAT_W-1:0] k_raw_q, dims_raw_q;
  logic [1:0]           norm_q;
  logic [DCW-1:0]       dims_c;
  logic [KCW-1:0]       k_c;
  logic [KW-1:0]        last_slot;

  // store and point assembly
  logic signed [FEAT_W-1:0] feat_mem [FDEPTH];
  logic [CLW-1:0]           cls_mem [MAX_POINTS];
  logic signed [FEAT_W-1:0] qbuf [MAX_DIMS];
  logic [CW-1:0]            cnt_q;
  logic [DW-1:0]            pos_q;
  logic                     ovf_q;
  logic                     in_acc, pos_last;
  logic [CLW-1:0]           tag_sat;

  // scan
  logic [PW-1:0]            pt_q;
  logic [DW-1:0]            d_q;
  logic                     d_last;
  dist_ctl_t                ctl0_q;
  logic signed [FEAT_W-1:0] tv_q, qv_q;
  logic                     dist_done;
  logic [DIST_W-1:0]        pt_dist, dist_q;
  logic                     pt_last;

  // heap
  logic [DIST_W-1:0] hd_q [MAX_NEIGHBOURS];
  logic [PW-1:0]     hi_q [MAX_NEIGHBOURS];
  logic [DIST_W-1:0] td_q;
  logic [PW-1:0]     ti_q;
  logic [KW-1:0]     m_q, j_q, par;
  logic [KW:0]       ch, ch1, ch_sel;

  // vote
  logic [KW-1:0]     s_q;
  logic [CLW-1:0]    cls_rd_q, lead_q, lead_d;
  logic [KCW-1:0]    votes_q [NUM_CLASSES];
  logic [KCW-1:0]    lead_cnt_q, lead_cnt_d, vote_new;

  // finished result waits in fin_q until the output register is free
  out_word_t fin_q;
  out_word_t res_q;
  logic      out_vld_q;

  // clamp registers into their legal ranges
  always_comb begin
    if (dims_raw_q == '0) dims_c = DCW'(1);
    else if (32'(dims_raw_q) > MAX_DIMS) dims_c = DCW'(MAX_DIMS);
    else dims_c = DCW'(dims_raw_q);
    if (k_raw_q == '0) k_c = KCW'(1);
    else if (32'(k_raw_q) > MAX_NEIGHBOURS) k_c = KCW'(MAX_NEIGHBOURS);
    else k_c = KCW'(k_raw_q);
  end
  assign last_slot = KW'(k_c - KCW'(1));

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign pos_last    = (DCW'(pos_q) + DCW'(1)) >= dims_c;
  assign tag_sat     = (32'(in_i.data.class_tag) >= NUM_CLASSES) ?
                       CLW'(NUM_CLASSES - 1) : CLW'(in_i.data.class_tag);
  assign d_last      = (DCW'(d_q) + DCW'(1)) >= dims_c;
  assign pt_last     = (CW'(pt_q) + CW'(1)) == cnt_q;

  // sift-down child pick and sift-up parent
  always_comb begin
    ch  = {m_q, 1'b1};
    ch1 = ch + (KW+1)'(1);
    ch_sel = ch;
    if ((ch1 < (KW+1)'(last_slot)) &&
        (hd_q[ch1[KW-1:0]] > hd_q[ch[KW-1:0]])) begin
      ch_sel = ch1;
    end
    par = KW'((j_q - KW'(1)) >> 1);
  end

  // majority tracking: another class takes the lead only on a strictly larger count
  always_comb begin
    vote_new   = votes_q[cls_rd_q] + KCW'(1);
    lead_d     = lead_q;
    lead_cnt_d = lead_cnt_q;
    if (s_q == '0 || cls_rd_q == lead_q) begin
      lead_d     = cls_rd_q;
      lead_cnt_d = vote_new;
    end else if (vote_new > lead_cnt_q) begin
      lead_d     = cls_rd_q;
      lead_cnt_d = vote_new;
    end
  end

  // memories: write on accepted words, read once per cycle
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.data.cmd == CMD_TRAIN && 32'(cnt_q) < MAX_POINTS) begin
      feat_mem[{cnt_q[PW-1:0], pos_q}] <= in_i.data.feature_value;
      if (pos_last) begin
        cls_mem[cnt_q[PW-1:0]] <= tag_sat;
      end
    end
    if (in_acc && in_i.data.cmd == CMD_QUERY) begin
      qbuf[pos_q] <= in_i.data.feature_value;
    end
    tv_q     <= feat_mem[{pt_q, d_q}];
    qv_q     <= qbuf[d_q];
    cls_rd_q <= cls_mem[hi_q[s_q]];
  end

  kbc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl0_q),
    .query_i (qv_q),
    .train_i (tv_q),
    .done_o  (dist_done),
    .dist_o  (pt_dist)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_raw_q    <= CFG_DAT_W'(1);
      norm_q     <= 2'd2;
      dims_raw_q <= CFG_DAT_W'(16);
      cnt_q      <= '0;
      pos_q      <= '0;
      ovf_q      <= 1'b0;
      pt_q       <= '0;
      d_q        <= '0;
      ctl0_q     <= '0;
      dist_q     <= '0;
      td_q       <= '0;
      ti_q       <= '0;
      m_q        <= '0;
      j_q        <= '0;
      s_q        <= '0;
      lead_q     <= '0;
      lead_cnt_q <= '0;
      fin_q      <= '0;
      res_q      <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
        hd_q[i] <= DIST_MAX;
        hi_q[i] <= '0;
      end
      for (int i = 0; i < NUM_CLASSES; i++) votes_q[i] <= '0;
    end else begin
      if (state_q != ST_ISSUE) ctl0_q.vld <= 1'b0;
      if (out_vld_q && out_o.ready && state_q != ST_DONE) out_vld_q <= 1'b0;

      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_NEIGHBOUR_COUNT: k_raw_q    <= cfg_i.data.data;
          REG_NORM_SELECT:     norm_q     <= cfg_i.data.data[1:0];
          REG_DIMS_IN_USE:     dims_raw_q <= cfg_i.data.data;
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_i.data.cmd)
              CMD_CLEAR: begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
                pos_q <= '0;
              end
              CMD_TRAIN: begin
                pos_q <= pos_last ? '0 : pos_q + DW'(1);
                if (32'(cnt_q) < MAX_POINTS) begin
                  if (pos_last) cnt_q <= cnt_q + CW'(1);
                end else if (pos_last) begin
                  ovf_q <= 1'b1;
                end
              end
              CMD_QUERY: begin
                pos_q <= pos_last ? '0 : pos_q + DW'(1);
                if (pos_last) begin
                  if (cnt_q == '0) begin
                    fin_q <= '{predicted_class: '0, store_empty: 1'b1,
                               store_overflowed: ovf_q};
                    state_q <= ST_DONE;
                  end else begin
                    for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
                      hd_q[i] <= DIST_MAX;
                      hi_q[i] <= '0;
                    end
                    for (int i = 0; i < NUM_CLASSES; i++) votes_q[i] <= '0;
                    pt_q    <= '0;
                    d_q     <= '0;
                    state_q <= ST_ISSUE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        // one feature read per cycle into the distance pipeline
        ST_ISSUE: begin
          ctl0_q <= '{vld: 1'b1, first: (d_q == '0), last: d_last,
                      l1: (norm_q == 2'd1)};
          if (d_last) begin
            d_q     <= '0;
            state_q <= ST_WAITD;
          end else begin
            d_q <= d_q + DW'(1);
          end
        end
        ST_WAITD: begin
          if (dist_done) begin
            dist_q <= pt_dist;
            if (pt_dist > hd_q[0]) begin
              if (pt_last) begin
                s_q     <= '0;
                state_q <= ST_VREAD;
              end else begin
                pt_q    <= pt_q + PW'(1);
                state_q <= ST_ISSUE;
              end
            end else begin
              td_q    <= hd_q[last_slot];
              ti_q    <= hi_q[last_slot];
              m_q     <= '0;
              state_q <= ST_SDOWN;
            end
          end
        end
        // drop the root: move the last entry down one level a cycle
        ST_SDOWN: begin
          if (ch < (KW+1)'(last_slot) && td_q < hd_q[ch_sel[KW-1:0]]) begin
            hd_q[m_q] <= hd_q[ch_sel[KW-1:0]];
            hi_q[m_q] <= hi_q[ch_sel[KW-1:0]];
            m_q       <= ch_sel[KW-1:0];
          end else begin
            hd_q[m_q] <= td_q;
            hi_q[m_q] <= ti_q;
            j_q       <= last_slot;
            state_q   <= ST_SUP;
          end
        end
        // insert the new point at the last slot and move it up
        ST_SUP: begin
          if (j_q == '0 || hd_q[par] > dist_q) begin
            hd_q[j_q] <= dist_q;
            hi_q[j_q] <= pt_q;
            if (pt_last) begin
              s_q     <= '0;
              state_q <= ST_VREAD;
            end else begin
              pt_q    <= pt_q + PW'(1);
              state_q <= ST_ISSUE;
            end
          end else begin
            hd_q[j_q] <= hd_q[par];
            hi_q[j_q] <= hi_q[par];
            j_q       <= par;
          end
        end
        ST_VREAD: state_q <= ST_VACC;
        ST_VACC: begin
          votes_q[cls_rd_q] <= vote_new;
          lead_q     <= lead_d;
          lead_cnt_q <= lead_cnt_d;
          if (s_q == last_slot) begin
            fin_q <= '{predicted_class: TAG_W'(lead_d), store_empty: 1'b0,
                       store_overflowed: ovf_q};
            state_q <= ST_DONE;
          end else begin
            s_q     <= s_q + KW'(1);
            state_q <= ST_VREAD;
          end
        end
        // hold the finished word until the output register frees up
        ST_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            res_q     <= fin_q;
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = res_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_POINTS) else $error("point count beyond store");
  a_empty_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.store_empty |-> res_q.predicted_class == '0)
    else $error("empty store with nonzero class");
  a_sift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SDOWN |-> (m_q < last_slot || m_q == '0))
    else $error("sift position past last slot");
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_done |-> state_q == ST_WAITD) else $error("distance with no waiter");

endmodule
